// ----- hdl/pitch_scale_quantizer_core_assert.svh -----
// ----------------------------------------------------------------------------
// Pitch scale quantizer assertion macros
// Concurrent checks used at the end of the quantizer top level.
// ----------------------------------------------------------------------------
`ifndef PITCH_SCALE_QUANTIZER_CORE_ASSERT_SVH
`define PITCH_SCALE_QUANTIZER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PSQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PSQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/psq_pkg.sv -----
// ----------------------------------------------------------------------------
// Pitch scale quantizer package
// Widths, codes, scale ratio constants and midpoint thresholds shared by
// the quantizer top level and its split multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

  // Field and datapath widths
  localparam int unsigned FREQ_WIDTH_DEF = 32;
  localparam int unsigned BASE_W         = 31;
  localparam int unsigned RATIO_BITS     = 30;
  localparam int unsigned OPND_W         = 32;
  localparam int unsigned NUM_LANES      = 12;
  localparam int unsigned PIPE_DEPTH     = 9;
  localparam int unsigned DEG_W          = 4;
  localparam int unsigned OCT_W          = 6;
  localparam int unsigned OCT_INT_W      = 7;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned CFG_DATA_W     = 31;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SEL = 1'b1;

  // Reset root: 55 Hz in Q15.16
  localparam logic [BASE_W-1:0] BASE_RESET = 31'd3604480;

  // Octave field clamp limits
  localparam logic signed [OCT_INT_W-1:0] OCT_HI = 7'sd31;
  localparam logic signed [OCT_INT_W-1:0] OCT_LO = -7'sd32;

  // Scale lengths
  localparam logic [DEG_W-1:0] PENTA_LEN  = 4'd5;
  localparam logic [DEG_W-1:0] CHROMA_LEN = 4'd12;

  // Next-octave root ratio, Q2.30
  localparam logic [OPND_W-1:0] RATIO_TWO = 32'h8000_0000;

  typedef enum logic {
    SCALE_PENTA  = 1'b0,
    SCALE_CHROMA = 1'b1
  } scale_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // Load strobes for the two register stages of a split multiplier
  typedef struct packed {
    logic load_pp;
    logic load_sum;
  } mul_en_t;

  function automatic logic [DEG_W-1:0] scale_len(input scale_t sel);
    return (sel == SCALE_CHROMA) ? CHROMA_LEN : PENTA_LEN;
  endfunction

  // Ratio in Q2.30 for a degree; the scale length selects the next root
  function automatic logic [OPND_W-1:0] scale_ratio(input scale_t sel,
                                                    input logic [DEG_W-1:0] idx);
    logic [OPND_W-1:0] r;
    r = '0;
    if (idx == scale_len(sel)) begin
      r = RATIO_TWO;
    end else if (sel == SCALE_CHROMA) begin
      unique case (idx)
        4'd0:    r = 32'd1073741824;
        4'd1:    r = 32'd1137589835;
        4'd2:    r = 32'd1205234447;
        4'd3:    r = 32'd1276901417;
        4'd4:    r = 32'd1352829926;
        4'd5:    r = 32'd1433273380;
        4'd6:    r = 32'd1518500250;
        4'd7:    r = 32'd1608794974;
        4'd8:    r = 32'd1704458901;
        4'd9:    r = 32'd1805811301;
        4'd10:   r = 32'd1913190429;
        4'd11:   r = 32'd2026954652;
        default: r = '0;
      endcase
    end else begin
      unique case (idx)
        4'd0:    r = 32'd1073741824;
        4'd1:    r = 32'd1276679029;
        4'd2:    r = 32'd1433445335;
        4'd3:    r = 32'd1608465252;
        4'd4:    r = 32'd1913407930;
        default: r = '0;
      endcase
    end
    return r;
  endfunction

  // Sum of two neighboring ratios: the item lies past the midpoint of
  // degrees lane-1 and lane when y * threshold < 2 * x * 2^30
  function automatic logic [OPND_W-1:0] lane_thresh(input scale_t sel,
                                                    input logic [DEG_W-1:0] lane);
    logic [OPND_W-1:0] t;
    t = '0;
    if (sel == SCALE_CHROMA) begin
      unique case (lane)
        4'd1:    t = 32'd2211331659;
        4'd2:    t = 32'd2342824282;
        4'd3:    t = 32'd2482135864;
        4'd4:    t = 32'd2629731343;
        4'd5:    t = 32'd2786103306;
        4'd6:    t = 32'd2951773630;
        4'd7:    t = 32'd3127295224;
        4'd8:    t = 32'd3313253875;
        4'd9:    t = 32'd3510270202;
        4'd10:   t = 32'd3719001730;
        4'd11:   t = 32'd3940145081;
        4'd12:   t = 32'd4174438300;
        default: t = '0;
      endcase
    end else begin
      unique case (lane)
        4'd1:    t = 32'd2350420853;
        4'd2:    t = 32'd2710124364;
        4'd3:    t = 32'd3041910587;
        4'd4:    t = 32'd3521873182;
        4'd5:    t = 32'd4060891578;
        default: t = '0;
      endcase
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/psq_mul2.sv -----
// ----------------------------------------------------------------------------
// Split two-stage multiplier
// Multiplies a wide unsigned operand by a 32-bit operand as two half-width
// partial products in the first stage and adds them in the second.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_mul2 #(
  parameter int unsigned AW = psq_pkg::FREQ_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire psq_pkg::mul_en_t              en,
  input  wire logic [AW-1:0]                 a,
  input  wire logic [psq_pkg::OPND_W-1:0]    b,
  output logic [AW+psq_pkg::OPND_W-1:0]      prod
);

  import psq_pkg::*;

  localparam int unsigned LO_W = (AW + 1) / 2;
  localparam int unsigned HI_W = AW - LO_W;
  localparam int unsigned PW   = AW + OPND_W;

  logic [LO_W+OPND_W-1:0] pp_lo_r, pp_lo_nxt;
  logic [HI_W+OPND_W-1:0] pp_hi_r, pp_hi_nxt;
  logic [PW-1:0]          prod_r, prod_nxt;

  // Form partial products on the low and high halves
  always_comb begin
    pp_lo_nxt = (LO_W+OPND_W)'(a[LO_W-1:0]) * (LO_W+OPND_W)'(b);
    pp_hi_nxt = (HI_W+OPND_W)'(a[AW-1:LO_W]) * (HI_W+OPND_W)'(b);
  end

  always_ff @(posedge clk) begin
    if (en.load_pp) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
    end
  end

  // Align and add the partial products
  assign prod_nxt = (PW'(pp_hi_r) << LO_W) + PW'(pp_lo_r);

  always_ff @(posedge clk) begin
    if (en.load_sum) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- hdl/pitch_scale_quantizer_core.sv -----
// ----------------------------------------------------------------------------
// Pitch scale quantizer core
// Snaps a Q16.16 frequency to the nearest pentatonic or chromatic note built
// on a programmable root, with octave, degree and status flags.
//
//   Channel  Dir  Handshake             Payload
//   in       in   in_valid / in_stall   in_freq_in
//   out      out  out_valid / out_stall out_freq_out, out_degree, out_octave,
//                                       out_status
//   cfg      in   cfg_we                cfg_index, cfg_data
//
// One item per cycle while out_stall is low, through nine register stages.
// Stages: capture, normalize, two-stage lane multipliers, midpoint compare,
// two-stage output multiplier, rounding add, shift and saturate.
// Reset (rst_n low, synchronous) empties the pipeline and loads 55 Hz,
// pentatonic. Each stage loads when empty or when its successor moves, so
// bubbles collapse; in_stall rises only with all nine stages full and
// out_stall high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pitch_scale_quantizer_core_assert.svh"

module pitch_scale_quantizer_core #(
  parameter int unsigned FREQ_WIDTH = psq_pkg::FREQ_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [psq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [psq_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [FREQ_WIDTH-1:0]             in_freq_in,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [FREQ_WIDTH-1:0]                  out_freq_out,
  output logic [psq_pkg::DEG_W-1:0]              out_degree,
  output logic [psq_pkg::OCT_W-1:0]              out_octave,
  output logic [psq_pkg::STATUS_W-1:0]           out_status
);

  import psq_pkg::*;

  localparam int unsigned XW    = (FREQ_WIDTH > BASE_W) ? FREQ_WIDTH : BASE_W;
  localparam int unsigned SW    = $clog2(XW);
  localparam int unsigned PW    = XW + OPND_W;
  localparam int unsigned SHA_W = SW + 1;

  function automatic logic [SW-1:0] msb_idx(input logic [XW-1:0] v);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = 0; i < XW; i++) begin
      if (v[i]) idx = SW'(i);
    end
    return idx;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0] base_freq_r;
  scale_t            scale_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_freq_r <= BASE_RESET;
      scale_sel_r <= SCALE_PENTA;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BASE_FREQ) begin
        base_freq_r <= cfg_data[BASE_W-1:0];
      end else if (cfg_index == CFG_SCALE_SEL) begin
        scale_sel_r <= scale_t'(cfg_data[0]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: valid bits and ready chain
  // --------------------------------------------------------------------------
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic [PIPE_DEPTH-1:0] rdy;

  always_comb begin
    rdy[PIPE_DEPTH-1] = !vld_r[PIPE_DEPTH-1] || !out_stall;
    for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    vld_nxt = vld_r;
    if (rdy[0]) vld_nxt[0] = in_valid;
    for (int i = 1; i < PIPE_DEPTH; i++) begin
      if (rdy[i]) vld_nxt[i] = vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[PIPE_DEPTH-1];

  // --------------------------------------------------------------------------
  // Stage 1: capture item, find leading ones of input and root
  // --------------------------------------------------------------------------
  logic [BASE_W-1:0]     base_eff;
  logic [FREQ_WIDTH-1:0] f1_r;
  logic [BASE_W-1:0]     b1_r;
  logic [SW-1:0]         lf1_r, lb1_r;
  scale_t                sel1_r;
  logic                  zero1_r;

  assign base_eff = (base_freq_r == '0) ? BASE_W'(1) : base_freq_r;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      f1_r    <= in_freq_in;
      b1_r    <= base_eff;
      lf1_r   <= msb_idx(XW'(in_freq_in));
      lb1_r   <= msb_idx(XW'(base_eff));
      sel1_r  <= scale_sel_r;
      zero1_r <= (in_freq_in == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: octave normalize; above the root shift the root up, below it
  // shift the input up, then back off one when the shift overshoots
  // --------------------------------------------------------------------------
  logic [XW-1:0]               f1_x, b1_x, a_op, o_op, sh_val, nrm;
  logic                        above, fit;
  logic [SW-1:0]               amt, oct_cnt;
  logic [OCT_INT_W-1:0]        oct_mag;
  logic [XW-1:0]               x2_nxt, y2_nxt;
  logic signed [OCT_INT_W-1:0] oct2_nxt;
  logic [SW-1:0]               m2_nxt;

  always_comb begin
    f1_x     = XW'(f1_r);
    b1_x     = XW'(b1_r);
    above    = (f1_x >= b1_x);
    amt      = above ? (lf1_r - lb1_r) : (lb1_r - lf1_r);
    a_op     = above ? b1_x : f1_x;
    o_op     = above ? f1_x : b1_x;
    sh_val   = a_op << amt;
    fit      = (sh_val <= o_op);
    nrm      = fit ? sh_val : (sh_val >> 1);
    oct_cnt  = fit ? amt : (amt - 1'b1);
    oct_mag  = OCT_INT_W'(oct_cnt);
    x2_nxt   = above ? f1_x : nrm;
    y2_nxt   = above ? nrm : b1_x;
    oct2_nxt = above ? signed'(oct_mag) : -signed'(oct_mag);
    m2_nxt   = above ? '0 : oct_cnt;
  end

  logic [XW-1:0]               x2_r, y2_r;
  logic signed [OCT_INT_W-1:0] oct2_r;
  logic [SW-1:0]               m2_r;
  scale_t                      sel2_r;
  logic                        zero2_r;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      x2_r    <= x2_nxt;
      y2_r    <= y2_nxt;
      oct2_r  <= oct2_nxt;
      m2_r    <= m2_nxt;
      sel2_r  <= sel1_r;
      zero2_r <= zero1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 3-4: octave start times each midpoint threshold, one lane each
  // --------------------------------------------------------------------------
  mul_en_t       lane_en;
  logic [PW-1:0] lane_prod [NUM_LANES];

  assign lane_en.load_pp  = rdy[2];
  assign lane_en.load_sum = rdy[3];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    psq_mul2 #(
      .AW (XW)
    ) u_mul (
      .clk  (clk),
      .en   (lane_en),
      .a    (y2_r),
      .b    (lane_thresh(sel2_r, DEG_W'(g + 1))),
      .prod (lane_prod[g])
    );
  end

  logic [XW-1:0]               x3_r, y3_r, x4_r, y4_r;
  logic signed [OCT_INT_W-1:0] oct3_r, oct4_r;
  logic [SW-1:0]               m3_r, m4_r;
  scale_t                      sel3_r, sel4_r;
  logic                        zero3_r, zero4_r;

  // Carry side data alongside the lane multipliers
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      x3_r    <= x2_r;
      y3_r    <= y2_r;
      oct3_r  <= oct2_r;
      m3_r    <= m2_r;
      sel3_r  <= sel2_r;
      zero3_r <= zero2_r;
    end
    if (rdy[3]) begin
      x4_r    <= x3_r;
      y4_r    <= y3_r;
      oct4_r  <= oct3_r;
      m4_r    <= m3_r;
      sel4_r  <= sel3_r;
      zero4_r <= zero3_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: count midpoints passed; equal to the scale length means the
  // next-octave root is strictly closer
  // --------------------------------------------------------------------------
  logic [PW-1:0]    target;
  logic [DEG_W-1:0] len4;
  logic [DEG_W-1:0] cnt5_nxt;

  always_comb begin
    target   = PW'({x4_r, {(RATIO_BITS + 1){1'b0}}});
    len4     = scale_len(sel4_r);
    cnt5_nxt = '0;
    for (int j = 0; j < NUM_LANES; j++) begin
      if ((DEG_W'(j + 1) <= len4) && (lane_prod[j] < target)) begin
        cnt5_nxt = cnt5_nxt + 1'b1;
      end
    end
  end

  logic [DEG_W-1:0]            cnt5_r;
  logic [XW-1:0]               y5_r;
  logic signed [OCT_INT_W-1:0] oct5_r;
  logic [SW-1:0]               m5_r;
  scale_t                      sel5_r;
  logic                        zero5_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      cnt5_r  <= cnt5_nxt;
      y5_r    <= y4_r;
      oct5_r  <= oct4_r;
      m5_r    <= m4_r;
      sel5_r  <= sel4_r;
      zero5_r <= zero4_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 6-7: octave start times the chosen ratio
  // --------------------------------------------------------------------------
  logic                        is_root2;
  logic [OPND_W-1:0]           ratio5;
  logic [DEG_W-1:0]            deg6_nxt;
  logic signed [OCT_INT_W-1:0] oct6_nxt;
  mul_en_t                     out_en;
  logic [PW-1:0]               prod7;

  always_comb begin
    is_root2 = (cnt5_r == scale_len(sel5_r));
    ratio5   = scale_ratio(sel5_r, cnt5_r);
    deg6_nxt = is_root2 ? '0 : cnt5_r;
    oct6_nxt = oct5_r + OCT_INT_W'(is_root2);
  end

  assign out_en.load_pp  = rdy[5];
  assign out_en.load_sum = rdy[6];

  psq_mul2 #(
    .AW (XW)
  ) u_out_mul (
    .clk  (clk),
    .en   (out_en),
    .a    (y5_r),
    .b    (ratio5),
    .prod (prod7)
  );

  logic [DEG_W-1:0]            deg6_r, deg7_r;
  logic signed [OCT_INT_W-1:0] oct6_r, oct7_r;
  logic [SW-1:0]               m6_r, m7_r;
  logic                        zero6_r, zero7_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      deg6_r  <= deg6_nxt;
      oct6_r  <= oct6_nxt;
      m6_r    <= m5_r;
      zero6_r <= zero5_r;
    end
    if (rdy[6]) begin
      deg7_r  <= deg6_r;
      oct7_r  <= oct6_r;
      m7_r    <= m6_r;
      zero7_r <= zero6_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: add the rounding half below the output point
  // --------------------------------------------------------------------------
  logic [SHA_W-1:0] half_sh;
  logic [PW:0]      rnd8_nxt;

  always_comb begin
    half_sh  = SHA_W'(RATIO_BITS - 1) + SHA_W'(m7_r);
    rnd8_nxt = (PW + 1)'(prod7) + ((PW + 1)'(1) << half_sh);
  end

  logic [PW:0]                 rnd8_r;
  logic [DEG_W-1:0]            deg8_r;
  logic signed [OCT_INT_W-1:0] oct8_r;
  logic [SW-1:0]               m8_r;
  logic                        zero8_r;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      rnd8_r  <= rnd8_nxt;
      deg8_r  <= deg7_r;
      oct8_r  <= oct7_r;
      m8_r    <= m7_r;
      zero8_r <= zero7_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: drop the fraction, saturate, clamp octave, register outputs
  // --------------------------------------------------------------------------
  logic [SHA_W-1:0]            rnd_sh;
  logic [PW:0]                 quot;
  logic                        sat;
  logic signed [OCT_INT_W-1:0] oct_c;
  logic [FREQ_WIDTH-1:0]       freq_nxt;
  logic [DEG_W-1:0]            deg_nxt;
  logic [OCT_W-1:0]            octave_nxt;
  status_t                     status_nxt;

  always_comb begin
    rnd_sh = SHA_W'(RATIO_BITS) + SHA_W'(m8_r);
    quot   = rnd8_r >> rnd_sh;
    sat    = |quot[PW:FREQ_WIDTH];
    if (oct8_r > OCT_HI) begin
      oct_c = OCT_HI;
    end else if (oct8_r < OCT_LO) begin
      oct_c = OCT_LO;
    end else begin
      oct_c = oct8_r;
    end
    if (zero8_r) begin
      freq_nxt   = '0;
      deg_nxt    = '0;
      octave_nxt = '0;
      status_nxt = ST_ZERO;
    end else begin
      freq_nxt   = sat ? '1 : quot[FREQ_WIDTH-1:0];
      deg_nxt    = deg8_r;
      octave_nxt = oct_c[OCT_W-1:0];
      status_nxt = sat ? ST_SAT : ST_OK;
    end
  end

  logic [FREQ_WIDTH-1:0] out_freq_r;
  logic [DEG_W-1:0]      out_deg_r;
  logic [OCT_W-1:0]      out_oct_r;
  status_t               out_status_r;

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      out_freq_r   <= freq_nxt;
      out_deg_r    <= deg_nxt;
      out_oct_r    <= octave_nxt;
      out_status_r <= status_nxt;
    end
  end

  assign out_freq_out = out_freq_r;
  assign out_degree   = out_deg_r;
  assign out_octave   = out_oct_r;
  assign out_status   = out_status_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  logic zero_res, zero_clr, sat_res, full_stall, in_xfer;

  assign zero_res   = out_valid && (out_status == ST_ZERO);
  assign zero_clr   = (out_freq_out == '0) && (out_degree == '0) && (out_octave == '0);
  assign sat_res    = out_valid && (out_status == ST_SAT);
  assign full_stall = (&vld_r) && out_stall;
  assign in_xfer    = in_valid && !in_stall;

  `PSQ_ASSERT_IMP(a_zero_result, clk, rst_n, zero_res, zero_clr, "zero input gave nonzero fields")
  `PSQ_ASSERT_IMP(a_sat_result, clk, rst_n, sat_res, &out_freq_out, "saturation below full scale")
  `PSQ_ASSERT_IMP(a_stall_full, clk, rst_n, in_stall, full_stall, "input stall with a free stage")
  `PSQ_ASSERT_NXT(a_in_lands, clk, rst_n, in_xfer, vld_r[0], "input transfer did not land")

endmodule

`default_nettype wire
